// ----- hw/rtl/apool_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// apool_pkg: shared types and constants for the 2-D average pooling block
// Register indexes, geometry limits and the sequencer state type.
// ----------------------------------------------------------------------------
package apool_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_KERNEL  = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int SLOT_BITS   = $clog2(MAX_KERNEL);
    localparam int ADDR_BITS   = COL_BITS + SLOT_BITS;
    localparam int SUM_BITS    = SAMPLE_BITS + 2 * SLOT_BITS + 2;
    localparam int QUO_BITS    = SUM_BITS;

    localparam logic [2:0] REG_CHANNELS = 3'd0;
    localparam logic [2:0] REG_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_WIDTH    = 3'd2;
    localparam logic [2:0] REG_KERNEL_H = 3'd3;
    localparam logic [2:0] REG_KERNEL_W = 3'd4;
    localparam logic [2:0] REG_STRIDE_H = 3'd5;
    localparam logic [2:0] REG_STRIDE_W = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_CHECK,
        ST_READ,
        ST_ACCUM,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage : apool_pkg
`default_nettype wire

// ----- hw/rtl/avg_pool2d_forward.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// avg_pool2d_forward: streaming 2-D average pooling, valid strided windows
// Line store of the last rows, one shared adder for the window sum, and a
// restoring divider for the mean, all under one small sequencer.
// ----------------------------------------------------------------------------
// channel   dir  handshake              payload
// s_axis    in   s_axis_tvalid/tready   tdata[15:0] sample
// m_axis    out  m_axis_tvalid/tready   tdata {out_col,out_row,channel,average},
//                                       tlast = last
// apb       in   psel/penable/pready    7 registers at 4*i
//
// Every word passes the idle, write and check states. One that closes a window
// then reads the store and adds once per window sample (store read, registered,
// then one add each), runs SUM_BITS (24) divider steps and hands off in done.
// The single store read port and the bit-per-cycle divider bound the pace.
// Reset clears the sequencer, counters and config registers; the store is not
// cleared. s_axis_tready is high only in idle; the output register frees the
// core, which stalls only when a second mean is ready while the first is held.
// ----------------------------------------------------------------------------
module avg_pool2d_forward
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] sample
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [15:0] average, [25:16] channel_index,
                                             // [37:26] out_row, [45:38] out_col, pad
    output logic             m_axis_tlast,   // last
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int AB = apool_pkg::ADDR_BITS;
    localparam int CB = apool_pkg::COL_BITS;
    localparam int SB = apool_pkg::SLOT_BITS;
    localparam int WB = apool_pkg::SUM_BITS;

    // configuration registers, kept as written
    logic [10:0] chan_reg;
    logic [12:0] hgt_reg;
    logic [8:0]  wid_reg;
    logic [3:0]  kh_reg, kw_reg, sh_reg, sw_reg;

    // clamped values
    logic [10:0] nch;
    logic [12:0] nh;
    logic [8:0]  nw;
    logic [3:0]  kh, kw, sh, sw;

    function automatic logic [3:0] clamp4(input logic [3:0] v, input logic [3:0] hi);
        logic [3:0] r;
        begin
            r = v;
            if (v == 4'd0) r = 4'd1;
            else if (v > hi) r = hi;
            return r;
        end
    endfunction

    always_comb
    begin
        nch = (chan_reg == 11'd0) ? 11'd1 : ((chan_reg > 11'd1024) ? 11'd1024 : chan_reg);
        nh  = (hgt_reg == 13'd0) ? 13'd1 : ((hgt_reg > 13'd4096) ? 13'd4096 : hgt_reg);
        nw  = (wid_reg == 9'd0) ? 9'd1 :
              ((wid_reg > 9'(apool_pkg::MAX_WIDTH)) ? 9'(apool_pkg::MAX_WIDTH) : wid_reg);
        kh  = clamp4(kh_reg, 4'(apool_pkg::MAX_KERNEL));
        kw  = clamp4(kw_reg, 4'(apool_pkg::MAX_KERNEL));
        sh  = clamp4(sh_reg, 4'd8);
        sw  = clamp4(sw_reg, 4'd8);
    end

    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg <= 11'd1;
            hgt_reg  <= 13'd1;
            wid_reg  <= 9'd1;
            kh_reg   <= 4'd1;
            kw_reg   <= 4'd1;
            sh_reg   <= 4'd1;
            sw_reg   <= 4'd1;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                apool_pkg::REG_CHANNELS: chan_reg <= pwdata[10:0];
                apool_pkg::REG_HEIGHT:   hgt_reg  <= pwdata[12:0];
                apool_pkg::REG_WIDTH:    wid_reg  <= pwdata[8:0];
                apool_pkg::REG_KERNEL_H: kh_reg   <= pwdata[3:0];
                apool_pkg::REG_KERNEL_W: kw_reg   <= pwdata[3:0];
                apool_pkg::REG_STRIDE_H: sh_reg   <= pwdata[3:0];
                apool_pkg::REG_STRIDE_W: sw_reg   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            apool_pkg::REG_CHANNELS: prdata = {21'd0, chan_reg};
            apool_pkg::REG_HEIGHT:   prdata = {19'd0, hgt_reg};
            apool_pkg::REG_WIDTH:    prdata = {23'd0, wid_reg};
            apool_pkg::REG_KERNEL_H: prdata = {28'd0, kh_reg};
            apool_pkg::REG_KERNEL_W: prdata = {28'd0, kw_reg};
            apool_pkg::REG_STRIDE_H: prdata = {28'd0, sh_reg};
            apool_pkg::REG_STRIDE_W: prdata = {28'd0, sw_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // position counters and stride phase counters
    // ------------------------------------------------------------------
    logic [11:0] row_reg, row_next;
    logic [7:0]  col_reg, col_next;
    logic [9:0]  plane_reg, plane_next;
    // phase: distance since the row/col where a window could first close
    logic [3:0]  rph_reg, rph_next, cph_reg, cph_next;
    logic [11:0] orow_reg, orow_next;
    logic [7:0]  ocol_reg, ocol_next;

    // last row/col of the output grid: the next origin step overruns
    logic row_hit, col_hit, last_oh, last_ow;

    apool_pkg::state_t state_reg, state_next;

    logic [15:0] samp_reg;
    logic        win_reg;

    assign row_hit = ({1'b0, row_reg} + 13'd1 >= {9'd0, kh}) && (rph_reg == 4'd0);
    assign col_hit = ({1'b0, col_reg} + 9'd1 >= {5'd0, kw}) && (cph_reg == 4'd0);
    // last output row: origin r0 + sh + kh > nh
    assign last_oh = ({1'b0, row_reg} + 13'd1 + {9'd0, sh}) > nh;
    assign last_ow = ({1'b0, col_reg} + 9'd1 + {5'd0, sw}) > nw;

    // advance counters once per word
    logic advance;
    always_comb
    begin
        row_next   = row_reg;
        col_next   = col_reg;
        plane_next = plane_reg;
        rph_next   = rph_reg;
        cph_next   = cph_reg;
        orow_next  = orow_reg;
        ocol_next  = ocol_reg;
        if (advance)
        begin
            if ({1'b0, col_reg} + 9'd1 >= {5'd0, kw})
            begin
                cph_next = (cph_reg + 4'd1 == sw) ? 4'd0 : cph_reg + 4'd1;
                if (col_hit) ocol_next = ocol_reg + 8'd1;
            end
            col_next = col_reg + 8'd1;
            if ({1'b0, col_reg} + 9'd1 >= nw)
            begin
                col_next  = 8'd0;
                cph_next  = 4'd0;
                ocol_next = 8'd0;
                if ({1'b0, row_reg} + 13'd1 >= {9'd0, kh})
                begin
                    rph_next = (rph_reg + 4'd1 == sh) ? 4'd0 : rph_reg + 4'd1;
                    if (row_hit) orow_next = orow_reg + 12'd1;
                end
                row_next = row_reg + 12'd1;
                if ({1'b0, row_reg} + 13'd1 >= nh)
                begin
                    row_next  = 12'd0;
                    rph_next  = 4'd0;
                    orow_next = 12'd0;
                    plane_next = ({1'b0, plane_reg} + 11'd1 >= nch) ? 10'd0 : plane_reg + 10'd1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // line store
    // ------------------------------------------------------------------
    logic [15:0] store [apool_pkg::MAX_KERNEL * apool_pkg::MAX_WIDTH];
    logic        st_we;
    logic [AB-1:0] st_waddr, st_raddr;
    logic [15:0] st_rdata;

    always_ff @(posedge clk)
    begin
        if (st_we) store[st_waddr] <= samp_reg;
        st_rdata <= store[st_raddr];
    end

    assign st_waddr = {row_reg[SB-1:0], col_reg[CB-1:0]};

    // window walk: i over rows, j over cols
    logic [3:0]  wi_reg, wi_next, wj_reg, wj_next;
    logic [11:0] r0_reg;
    logic [7:0]  c0_reg;
    logic [11:0] rr;
    logic [7:0]  cc;
    assign rr = r0_reg + {8'd0, wi_reg};
    assign cc = c0_reg + {4'd0, wj_reg};
    assign st_raddr = {rr[SB-1:0], cc[CB-1:0]};

    logic signed [WB-1:0] sum_reg, sum_next;

    // divider: restoring, one quotient bit per cycle
    logic [WB-1:0] mag_reg, mag_next;
    logic [WB-1:0] rem_reg, rem_next;
    logic [WB-1:0] quo_reg, quo_next;
    logic [4:0]    dcnt_reg, dcnt_next;
    logic          neg_reg, neg_next;
    logic [6:0]    area;
    logic [WB:0]   trial;
    assign area  = {3'd0, kh} * {3'd0, kw};
    assign trial = {rem_reg, mag_reg[WB-1]} - {{(WB-6){1'b0}}, area};

    // result register
    logic        ovalid_reg;
    logic [47:0] odata_reg;
    logic        olast_reg;
    logic        lastflag_reg;
    logic [9:0]  rplane_reg;
    logic [11:0] rorow_reg;
    logic [7:0]  rocol_reg;
    logic        out_load;

    assign s_axis_tready = (state_reg == apool_pkg::ST_IDLE) && !cfg_wr;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tlast  = olast_reg;
    // mean moves to the output register once that register is free
    assign out_load = (state_reg == apool_pkg::ST_DONE) && (!ovalid_reg || m_axis_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            apool_pkg::ST_IDLE:  if (s_axis_tvalid && s_axis_tready) state_next = apool_pkg::ST_WRITE;
            apool_pkg::ST_WRITE: state_next = apool_pkg::ST_CHECK;
            apool_pkg::ST_CHECK: state_next = win_reg ? apool_pkg::ST_READ : apool_pkg::ST_IDLE;
            apool_pkg::ST_READ:  state_next = apool_pkg::ST_ACCUM;
            apool_pkg::ST_ACCUM:
                if (wi_reg + 4'd1 == kh && wj_reg + 4'd1 == kw) state_next = apool_pkg::ST_DIV;
                else state_next = apool_pkg::ST_READ;
            apool_pkg::ST_DIV:   if (dcnt_reg == 5'(WB - 1)) state_next = apool_pkg::ST_DONE;
            apool_pkg::ST_DONE:  if (!ovalid_reg || m_axis_tready) state_next = apool_pkg::ST_IDLE;
            default:             state_next = apool_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        st_we     = (state_reg == apool_pkg::ST_WRITE);
        advance   = (state_reg == apool_pkg::ST_CHECK);
        wi_next   = wi_reg;
        wj_next   = wj_reg;
        sum_next  = sum_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dcnt_next = dcnt_reg;
        neg_next  = neg_reg;
        unique case (state_reg)
            apool_pkg::ST_CHECK:
            begin
                wi_next  = 4'd0;
                wj_next  = 4'd0;
                sum_next = '0;
            end
            apool_pkg::ST_ACCUM:
            begin
                sum_next = sum_reg + WB'(signed'(st_rdata));
                if (wj_reg + 4'd1 == kw)
                begin
                    wj_next = 4'd0;
                    wi_next = wi_reg + 4'd1;
                end
                else wj_next = wj_reg + 4'd1;
                // magnitude plus half area, ready for the divider
                neg_next  = sum_next[WB-1];
                mag_next  = (sum_next[WB-1] ? -sum_next : sum_next) + WB'(area >> 1);
                rem_next  = '0;
                quo_next  = '0;
                dcnt_next = 5'd0;
            end
            apool_pkg::ST_DIV:
            begin
                mag_next = mag_reg << 1;
                if (!trial[WB])
                begin
                    rem_next = trial[WB-1:0];
                    quo_next = {quo_reg[WB-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[WB-2:0], mag_reg[WB-1]};
                    quo_next = {quo_reg[WB-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 5'd1;
            end
            default: ;
        endcase
    end

    logic [15:0] avg;
    assign avg = neg_reg ? 16'(-quo_reg) : quo_reg[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= apool_pkg::ST_IDLE;
            row_reg    <= '0;
            col_reg    <= '0;
            plane_reg  <= '0;
            rph_reg    <= '0;
            cph_reg    <= '0;
            orow_reg   <= '0;
            ocol_reg   <= '0;
            ovalid_reg <= 1'b0;
            dcnt_reg   <= '0;
            wi_reg     <= '0;
            wj_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dcnt_reg  <= dcnt_next;
            wi_reg    <= wi_next;
            wj_reg    <= wj_next;
            if (cfg_wr)
            begin
                row_reg   <= '0;
                col_reg   <= '0;
                plane_reg <= '0;
                rph_reg   <= '0;
                cph_reg   <= '0;
                orow_reg  <= '0;
                ocol_reg  <= '0;
            end
            else
            begin
                row_reg   <= row_next;
                col_reg   <= col_next;
                plane_reg <= plane_next;
                rph_reg   <= rph_next;
                cph_reg   <= cph_next;
                orow_reg  <= orow_next;
                ocol_reg  <= ocol_next;
            end
            if (out_load) ovalid_reg <= 1'b1;
            else if (m_axis_tready && ovalid_reg) ovalid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
        if (state_reg == apool_pkg::ST_IDLE) samp_reg <= s_axis_tdata;
        if (state_reg == apool_pkg::ST_WRITE)
        begin
            win_reg      <= row_hit && col_hit;
            r0_reg       <= row_reg + 12'd1 - {8'd0, kh};
            c0_reg       <= col_reg + 8'd1 - {4'd0, kw};
            rplane_reg   <= plane_reg;
            rorow_reg    <= orow_reg;
            rocol_reg    <= ocol_reg;
            lastflag_reg <= ({1'b0, plane_reg} + 11'd1 == nch) && last_oh && last_ow;
        end
        if (out_load)
        begin
            odata_reg <= {2'd0, rocol_reg, rorow_reg, rplane_reg, avg};
            olast_reg <= lastflag_reg;
        end
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != apool_pkg::ST_IDLE) |-> !s_axis_tready)
        else $error("input accepted while busy");
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !m_axis_tready) |=> ovalid_reg && $stable(odata_reg))
        else $error("result dropped before taken");
    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg) == apool_pkg::ST_DONE)
        else $error("result without divide");
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == apool_pkg::ST_DIV) |-> (dcnt_reg <= 5'(WB - 1)))
        else $error("divider step count overrun");

endmodule : avg_pool2d_forward
`default_nettype wire
